// File: sv/mts_pkg.sv
`default_nettype none

package mts_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // operation codes carried in s_tuser
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

`default_nettype wire

// File: sv/mts_ram.sv
`default_nettype none

module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/min_tracking_stack.sv
`default_nettype none

// Stack of signed 32-bit words that also reports the minimum of its contents.
// Input channel (s_*): one transfer is one operation; s_tuser selects push (0)
// or pop (1) and s_tdata carries the word to push (ignored on pop).
// Output channel (m_*): exactly one transfer per input transfer, in order,
// carrying the new top and new minimum in m_tdata and the empty/rejected
// flags in m_tuser. Empty stack reports the most negative value for both.
// Results: a push, or any rejected operation, shows its result in the cycle
// after acceptance. An accepted pop first moves to the read state, where the
// new top and new minimum come out of the synchronous entry and minima
// memories, and only then loads the output register. Throughput: one push
// per cycle while the output is not stalled; after a pop, no new operation is taken until its memory read completes.
// A push to a full stack or a pop from an empty one is rejected and leaves
// both stacks untouched.
// Reset empties both stacks (the counts and cached tops clear; memory contents
// are never used before being written).
// When the receiver stalls, the result is held in the output register and
// s_tready stays low until that transfer completes.

module min_tracking_stack (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [mts_pkg::DATA_W-1:0]     s_tdata,   // [31:0] value
  input  wire logic [0:0]                     s_tuser,   // [0] operation
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [2*mts_pkg::DATA_W-1:0]   m_tdata,   // [31:0] top_value, [63:32] min_value
  output logic      [1:0]                     m_tuser    // [0] is_empty, [1] rejected
);

  import mts_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic              state;
  logic [CNT_W-1:0]  entry_count;
  logic [CNT_W-1:0]  min_count;
  logic [DATA_W-1:0] top_reg;     // cached entry top, MOST_NEG when empty
  logic [DATA_W-1:0] min_reg;     // cached minima top, MOST_NEG when empty
  logic              pop_min;     // pending pop also removed the minima top
  logic [DATA_W-1:0] out_top;
  logic [DATA_W-1:0] out_min;
  logic              out_empty;
  logic              out_rej;

  logic              s_accept;
  logic              out_load;
  logic              is_full;
  logic              is_emp;
  logic              take_min;
  logic              e_we;
  logic              m_we;
  logic [DATA_W-1:0] e_rdata;
  logic [DATA_W-1:0] m_rdata;
  logic [ADDR_W-1:0] e_raddr;
  logic [ADDR_W-1:0] m_raddr;
  logic [DATA_W-1:0] new_top;
  logic [DATA_W-1:0] new_min;

  // Take a new operation only when idle and the output slot frees up.
  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign s_accept = s_tvalid && s_tready;

  // Load the output slot when an operation finishes: every accepted operation
  // except a pop that still has to read the memories, plus the pop's read cycle.
  assign out_load = (state == S_READ) ||
                    (s_accept && !((s_tuser[0] == OP_POP) && !is_emp));

  assign is_full  = (entry_count == CNT_W'(STACK_DEPTH));
  assign is_emp   = (entry_count == '0);
  assign take_min = (min_count == '0) || ($signed(s_tdata) <= $signed(min_reg));

  always_comb begin
    e_we = s_accept && (s_tuser[0] == OP_PUSH) && !is_full;
    m_we = e_we && take_min;
  end

  // Address the entry just below the current top; on a pop this becomes the new top.
  assign e_raddr = ADDR_W'(entry_count - CNT_W'(2));
  assign m_raddr = ADDR_W'(min_count - CNT_W'(2));

  mts_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_entry_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (ADDR_W'(entry_count)),
    .wdata (s_tdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  mts_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_minima_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (ADDR_W'(min_count)),
    .wdata (s_tdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  // Read state of a pop: counts are already decremented, read data is valid.
  always_comb begin
    new_top = (entry_count == '0) ? MOST_NEG : e_rdata;
    if (pop_min) begin
      new_min = (min_count == '0) ? MOST_NEG : m_rdata;
    end else begin
      new_min = min_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      min_count   <= '0;
      top_reg     <= MOST_NEG;
      min_reg     <= MOST_NEG;
      pop_min     <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_accept) begin
            if (s_tuser[0] == OP_PUSH) begin
              if (is_full) begin
                // reject: report the unchanged stack
                out_top   <= top_reg;
                out_min   <= min_reg;
                out_empty <= 1'b0;
                out_rej   <= 1'b1;
              end else begin
                entry_count <= entry_count + CNT_W'(1);
                top_reg     <= s_tdata;
                out_top     <= s_tdata;
                out_empty   <= 1'b0;
                out_rej     <= 1'b0;
                if (take_min) begin
                  min_count <= min_count + CNT_W'(1);
                  min_reg   <= s_tdata;
                  out_min   <= s_tdata;
                end else begin
                  out_min   <= min_reg;
                end
              end
            end else if (is_emp) begin
              out_top   <= MOST_NEG;
              out_min   <= MOST_NEG;
              out_empty <= 1'b1;
              out_rej   <= 1'b1;
            end else begin
              // drop the top; drop the minima top too when it matches
              entry_count <= entry_count - CNT_W'(1);
              pop_min     <= (min_count != '0) && (top_reg == min_reg);
              if ((min_count != '0) && (top_reg == min_reg)) begin
                min_count <= min_count - CNT_W'(1);
              end
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          top_reg   <= new_top;
          min_reg   <= new_min;
          out_top   <= new_top;
          out_min   <= new_min;
          out_empty <= (entry_count == '0);
          out_rej   <= 1'b0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {out_min, out_top};
  assign m_tuser = {out_rej, out_empty};

  // minima never outnumber entries
  a_min_le_entries: assert property (@(posedge clk) disable iff (rst)
    min_count <= entry_count)
    else $error("minima count exceeds entry count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(STACK_DEPTH))
    else $error("entry count beyond depth");

  a_read_completes: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_IDLE) && m_tvalid)
    else $error("pop did not produce a result");

  a_empty_reports_neg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata == {MOST_NEG, MOST_NEG}))
    else $error("empty result without most negative values");

endmodule

`default_nettype wire
